[hdl/mbrr_pkg.sv]
// ----------------------------------------------------------------------------
// mbrr_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// register responder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrr_pkg;

  localparam int REG_COUNT   = 12;
  localparam int MAX_READ    = 12;
  localparam int FRAME_BYTES = 32;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = 4;
  localparam int PTR_W       = 5;
  localparam int HDR_BYTES   = 6;
  localparam int MIN_FRAME   = 4;
  localparam int REQ_LEN     = 8;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;
  localparam logic [7:0] EXC_FLAG   = 8'h80;

  localparam logic [7:0] EXC_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ADDR  = 8'h02;
  localparam logic [7:0] EXC_COUNT = 8'h03;
  localparam logic [7:0] EXC_FAULT = 8'h04;
  localparam logic [7:0] EXC_CRC   = 8'h08;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_LIMIT = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_END,
    CMD_FAULT,
    CMD_LIMIT,
    CMD_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [15:0]      val_a;
    logic [15:0]      val_b;
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_EXC,
    MODE_READ,
    MODE_WRITE
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEND,
    ST_NOTE
  } back_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/mbrr_front.sv]
// ----------------------------------------------------------------------------
// mbrr_front
// Accepts input transactions, classifies them into commands and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrr_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       op,
  input  wire  [7:0]                       data_byte,
  input  wire                              last_byte,
  input  wire  [mbrr_pkg::IDX_W-1:0]       reg_index,
  input  wire  [15:0]                      limit_low,
  input  wire  [15:0]                      limit_high,
  input  wire  [15:0]                      local_value,
  output mbrr_pkg::cmd_t                   cmd,
  output logic                             cmd_valid,
  input  wire                              cmd_pop
);

  mbrr_pkg::cmd_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;

  mbrr_pkg::cmd_t new_cmd;
  logic           keep;
  logic           push;
  logic           idx_ok;

  assign idx_ok = reg_index < mbrr_pkg::IDX_W'(mbrr_pkg::REG_COUNT);

  always_comb begin
    new_cmd.data  = data_byte;
    new_cmd.idx   = reg_index;
    new_cmd.val_a = local_value;
    new_cmd.val_b = limit_high;
    new_cmd.kind  = mbrr_pkg::CMD_BYTE;
    keep          = 1'b1;
    case (op)
      mbrr_pkg::OP_BYTE: begin
        new_cmd.kind = last_byte ? mbrr_pkg::CMD_END : mbrr_pkg::CMD_BYTE;
      end
      mbrr_pkg::OP_FAULT: begin
        new_cmd.kind = mbrr_pkg::CMD_FAULT;
      end
      mbrr_pkg::OP_LIMIT: begin
        new_cmd.kind  = mbrr_pkg::CMD_LIMIT;
        new_cmd.val_a = limit_low;
        keep          = idx_ok;
      end
      mbrr_pkg::OP_SET: begin
        new_cmd.kind = mbrr_pkg::CMD_SET;
        keep         = idx_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= new_cmd;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (cmd_pop) begin
        rptr <= !rptr;
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/mbrr_back.sv]
// ----------------------------------------------------------------------------
// mbrr_back
// Executes commands: frame buffering with running CRC, request checks,
// register access and serial emission of reply bytes through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrr_back (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [7:0]                       bcast,
  input  mbrr_pkg::cmd_t                   cmd,
  input  wire                              cmd_valid,
  output logic                             cmd_pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             kind,
  output logic [7:0]                       tx_byte,
  output logic                             tx_last,
  output logic [mbrr_pkg::IDX_W-1:0]       written_index,
  output logic [15:0]                      written_value
);

  mbrr_pkg::back_state_t state;
  mbrr_pkg::back_state_t state_next;

  logic [mbrr_pkg::CNT_W-1:0] count;
  logic                       overrun;
  logic [7:0]                 hdr [mbrr_pkg::HDR_BYTES];
  logic [7:0]                 last1;
  logic [7:0]                 last2;
  logic [15:0]                crc_a;
  logic [15:0]                crc_b;
  logic [15:0]                crc_c;
  logic [15:0]                holding [mbrr_pkg::REG_COUNT];
  logic [15:0]                min_t   [mbrr_pkg::REG_COUNT];
  logic [15:0]                max_t   [mbrr_pkg::REG_COUNT];

  mbrr_pkg::mode_t            mode;
  logic [7:0]                 code;
  logic [mbrr_pkg::PTR_W-1:0] nbody;
  logic [mbrr_pkg::PTR_W-1:0] k;
  logic [15:0]                crc_tx;
  logic                       notify;
  logic [mbrr_pkg::IDX_W-1:0] wr_idx;
  logic [15:0]                wr_val;

  logic                       free;
  logic                       emit;
  logic                       emit_kind;
  logic [7:0]                 emit_byte;
  logic                       emit_last;
  logic                       is_bcast;
  logic [15:0]                w1;
  logic [15:0]                w2;
  logic [mbrr_pkg::IDX_W-1:0] ci;
  logic [15:0]                clamp_hi;
  logic [15:0]                clamp_v;

  mbrr_pkg::mode_t            dec_mode;
  logic [7:0]                 dec_code;
  logic [mbrr_pkg::PTR_W-1:0] dec_nbody;
  logic                       dec_reply;
  logic                       dec_write;

  logic [7:0]                 body;
  logic [mbrr_pkg::PTR_W-1:0] j;
  logic [mbrr_pkg::IDX_W-1:0] ridx;
  logic [15:0]                rval;
  logic                       crc_ok;

  assign free     = !out_valid || !out_stall;
  assign is_bcast = (hdr[0] == bcast);
  assign w1       = {hdr[2], hdr[3]};
  assign w2       = {hdr[4], hdr[5]};
  assign ci       = w1[mbrr_pkg::IDX_W-1:0];
  assign clamp_hi = (w2 > max_t[ci]) ? max_t[ci] : w2;
  assign clamp_v  = (clamp_hi < min_t[ci]) ? min_t[ci] : clamp_hi;
  assign crc_ok   = (last2 == crc_a[7:0]) && (last1 == crc_a[15:8]);

  // request checks
  always_comb begin
    dec_mode  = mbrr_pkg::MODE_EXC;
    dec_code  = mbrr_pkg::EXC_FAULT;
    dec_nbody = mbrr_pkg::PTR_W'(3);
    dec_reply = 1'b1;
    dec_write = 1'b0;
    if (overrun) begin
      dec_code = mbrr_pkg::EXC_FAULT;
    end else if (count < mbrr_pkg::CNT_W'(mbrr_pkg::MIN_FRAME)) begin
      dec_reply = 1'b0;
    end else if (!crc_ok) begin
      dec_code = mbrr_pkg::EXC_CRC;
    end else if (hdr[1] != mbrr_pkg::FUNC_READ && hdr[1] != mbrr_pkg::FUNC_WRITE) begin
      dec_code = mbrr_pkg::EXC_FUNC;
    end else if (count != mbrr_pkg::CNT_W'(mbrr_pkg::REQ_LEN)) begin
      dec_code = mbrr_pkg::EXC_COUNT;
    end else if (hdr[1] == mbrr_pkg::FUNC_READ) begin
      if (w2 == 16'd0 || w2 > 16'(mbrr_pkg::MAX_READ)) begin
        dec_code = mbrr_pkg::EXC_COUNT;
      end else if (({1'b0, w1} + {1'b0, w2}) > 17'(mbrr_pkg::REG_COUNT)) begin
        dec_code = mbrr_pkg::EXC_ADDR;
      end else begin
        dec_mode  = mbrr_pkg::MODE_READ;
        dec_nbody = mbrr_pkg::PTR_W'(3) + {w2[3:0], 1'b0};
      end
    end else begin
      if (w1 >= 16'(mbrr_pkg::REG_COUNT)) begin
        dec_code = mbrr_pkg::EXC_ADDR;
      end else begin
        dec_mode  = mbrr_pkg::MODE_WRITE;
        dec_nbody = mbrr_pkg::PTR_W'(mbrr_pkg::HDR_BYTES);
        dec_write = 1'b1;
      end
    end
  end

  // reply body byte
  always_comb begin
    j    = k - mbrr_pkg::PTR_W'(3);
    ridx = ci + j[mbrr_pkg::IDX_W:1];
    rval = holding[ridx];
    case (mode)
      mbrr_pkg::MODE_EXC: begin
        if (k == '0) begin
          body = hdr[0];
        end else if (k == mbrr_pkg::PTR_W'(1)) begin
          body = hdr[1] + mbrr_pkg::EXC_FLAG;
        end else begin
          body = code;
        end
      end
      mbrr_pkg::MODE_READ: begin
        if (k == '0) begin
          body = hdr[0];
        end else if (k == mbrr_pkg::PTR_W'(1)) begin
          body = hdr[1];
        end else if (k == mbrr_pkg::PTR_W'(2)) begin
          body = {w2[6:0], 1'b0};
        end else begin
          body = j[0] ? rval[7:0] : rval[15:8];
        end
      end
      mbrr_pkg::MODE_WRITE: begin
        body = hdr[k[2:0]];
      end
      default: begin
        body = 8'h00;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    emit_kind  = 1'b0;
    emit_byte  = 8'h00;
    emit_last  = 1'b0;
    case (state)
      mbrr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            mbrr_pkg::CMD_END:   state_next = mbrr_pkg::ST_DECIDE;
            mbrr_pkg::CMD_FAULT: state_next = is_bcast ? mbrr_pkg::ST_IDLE : mbrr_pkg::ST_SEND;
            default:             state_next = mbrr_pkg::ST_IDLE;
          endcase
        end
      end
      mbrr_pkg::ST_DECIDE: begin
        if (dec_reply && !is_bcast) begin
          state_next = mbrr_pkg::ST_SEND;
        end else if (dec_write) begin
          state_next = mbrr_pkg::ST_NOTE;
        end else begin
          state_next = mbrr_pkg::ST_IDLE;
        end
      end
      mbrr_pkg::ST_SEND: begin
        if (free) begin
          emit = 1'b1;
          if (k < nbody) begin
            emit_byte = body;
          end else if (k == nbody) begin
            emit_byte = crc_tx[7:0];
          end else begin
            emit_byte = crc_tx[15:8];
            emit_last = !notify;
            state_next = notify ? mbrr_pkg::ST_NOTE : mbrr_pkg::ST_IDLE;
          end
        end
      end
      mbrr_pkg::ST_NOTE: begin
        if (free) begin
          emit       = 1'b1;
          emit_kind  = 1'b1;
          emit_last  = 1'b1;
          state_next = mbrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbrr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= emit_kind;
      tx_byte       <= emit_byte;
      tx_last       <= emit_last;
      written_index <= emit_kind ? wr_idx : '0;
      written_value <= emit_kind ? wr_val : 16'h0000;
    end
    if (state == mbrr_pkg::ST_SEND && emit) begin
      k <= k + mbrr_pkg::PTR_W'(1);
      if (k < nbody) begin
        crc_tx <= mbrr_pkg::crc_byte(crc_tx, body);
      end
    end
    if (cmd_pop && (cmd.kind == mbrr_pkg::CMD_BYTE || cmd.kind == mbrr_pkg::CMD_END) &&
        count < mbrr_pkg::CNT_W'(mbrr_pkg::FRAME_BYTES)) begin
      if (count < mbrr_pkg::CNT_W'(mbrr_pkg::HDR_BYTES)) begin
        hdr[count[2:0]] <= cmd.data;
      end
      last1 <= cmd.data;
      last2 <= last1;
      crc_a <= crc_b;
      crc_b <= crc_c;
      crc_c <= mbrr_pkg::crc_byte((count == '0) ? mbrr_pkg::CRC_SEED : crc_c, cmd.data);
    end
    if (cmd_pop && cmd.kind == mbrr_pkg::CMD_FAULT) begin
      mode   <= mbrr_pkg::MODE_EXC;
      code   <= mbrr_pkg::EXC_FAULT;
      nbody  <= mbrr_pkg::PTR_W'(3);
      notify <= 1'b0;
      k      <= '0;
      crc_tx <= mbrr_pkg::CRC_SEED;
    end
    if (state == mbrr_pkg::ST_DECIDE) begin
      mode   <= dec_mode;
      code   <= dec_code;
      nbody  <= dec_nbody;
      notify <= dec_write;
      wr_idx <= ci;
      wr_val <= clamp_v;
      k      <= '0;
      crc_tx <= mbrr_pkg::CRC_SEED;
    end
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      overrun   <= 1'b0;
      for (int i = 0; i < mbrr_pkg::REG_COUNT; i++) begin
        holding[i] <= 16'h0000;
        min_t[i]   <= 16'h0000;
        max_t[i]   <= 16'hFFFF;
      end
    end else begin
      if (free) begin
        out_valid <= emit;
      end
      if (cmd_pop) begin
        case (cmd.kind)
          mbrr_pkg::CMD_BYTE, mbrr_pkg::CMD_END: begin
            if (count < mbrr_pkg::CNT_W'(mbrr_pkg::FRAME_BYTES)) begin
              count <= count + mbrr_pkg::CNT_W'(1);
            end else begin
              overrun <= 1'b1;
            end
          end
          mbrr_pkg::CMD_FAULT: begin
            count   <= '0;
            overrun <= 1'b0;
          end
          mbrr_pkg::CMD_LIMIT: begin
            min_t[cmd.idx] <= cmd.val_a;
            max_t[cmd.idx] <= cmd.val_b;
          end
          mbrr_pkg::CMD_SET: begin
            holding[cmd.idx] <= cmd.val_a;
          end
          default: begin
            count <= count;
          end
        endcase
      end
      if (state == mbrr_pkg::ST_DECIDE) begin
        count   <= '0;
        overrun <= 1'b0;
        if (dec_write) begin
          holding[ci] <= clamp_v;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/modbus_rtu_register_responder.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_register_responder
// Modbus RTU slave: buffers request bytes, serves functions 03 and 06 with
// CRC-16 checking and answers errors with exception frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one transaction per received
// byte, receive fault, limit load or local register set. A two-entry queue
// sits in front of the execution engine, so in_stall only rises when the
// queue is full, while the engine is busy checking a frame or sending a reply.
// Ordinary bytes, limit loads and local sets are executed in the idle state.
// The last byte of a frame takes the engine to a decide state that checks the
// request; the send state then emits the reply, one byte per cycle unless
// stalled: 5 bytes for an exception, 8 for a write echo (plus one notification),
// 5 + 2*quantity for a read, at most 29 results. The request CRC is computed
// as bytes arrive; the reply CRC is computed one byte per cycle while it is sent.
// Output channel (out_valid / out_stall) is fed from an output register;
// a stall simply holds the engine until the register is taken.
// The configuration channel (cfg_valid / cfg_ready, always ready) writes
// the node broadcast address. Synchronous reset clears the queue, frame
// state, limit tables (min 0, max 0xFFFF), holding registers and the
// broadcast address.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_register_responder (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [7:0]                       cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       op,
  input  wire  [7:0]                       data_byte,
  input  wire                              last_byte,
  input  wire  [mbrr_pkg::IDX_W-1:0]       reg_index,
  input  wire  [15:0]                      limit_low,
  input  wire  [15:0]                      limit_high,
  input  wire  [15:0]                      local_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             kind,
  output logic [7:0]                       tx_byte,
  output logic                             tx_last,
  output logic [mbrr_pkg::IDX_W-1:0]       written_index,
  output logic [15:0]                      written_value
);

  logic [7:0]     bcast;
  mbrr_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcast <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      bcast <= cfg_data;
    end
  end

  mbrr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .reg_index   (reg_index),
    .limit_low   (limit_low),
    .limit_high  (limit_high),
    .local_value (local_value),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  mbrr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .bcast         (bcast),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .tx_last       (tx_last),
    .written_index (written_index),
    .written_value (written_value)
  );

endmodule

`default_nettype wire

[hdl/mbrr_checker.sv]
// ----------------------------------------------------------------------------
// mbrr_checker
// Port-level checks for the Modbus RTU register responder.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrr_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire                              kind,
  input wire [7:0]                        tx_byte,
  input wire                              tx_last,
  input wire [mbrr_pkg::IDX_W-1:0]        written_index,
  input wire [15:0]                       written_value
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tx_byte) && $stable(kind))
    else $error("stalled output changed");

  a_note_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> tx_last && tx_byte == 8'h00)
    else $error("write notification not final or carries a byte");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> written_index == '0 && written_value == 16'h0000)
    else $error("transmit byte carries register fields");

  a_note_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> written_index < mbrr_pkg::IDX_W'(mbrr_pkg::REG_COUNT))
    else $error("notification names a register out of range");

endmodule

bind modbus_rtu_register_responder mbrr_checker u_mbrr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .tx_byte       (tx_byte),
  .tx_last       (tx_last),
  .written_index (written_index),
  .written_value (written_value)
);

`default_nettype wire
